### rtl/core/text_console_character_engine_defines.svh
// ----------------------------------------------------------------------------
// text console character engine assertion macros
// concurrent assertion shorthands clocked by clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition must never hold
`define TCE_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define TCE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define TCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TCE_ASSERT_NEVER(label, cond)
`define TCE_ASSERT_IMPLIES(label, ante, cons)
`define TCE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// shared constants, types and helpers of the text console character engine
// ----------------------------------------------------------------------------
package tce_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;
  localparam int CELLS     = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int CELL_W = 16;
  localparam int LIN_W  = 11;

  // control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // cell value after reset
  localparam logic [CELL_W-1:0] INIT_CELL = 16'h0700;

  // configuration register indexes
  localparam logic [1:0] REG_TEXT_COLOR    = 2'd0;
  localparam logic [1:0] REG_BACK_COLOR    = 2'd1;
  localparam logic [1:0] REG_SCROLL_ENABLE = 2'd2;
  localparam logic [1:0] REG_CURSOR_ENABLE = 2'd3;

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_SETPOS = 3'd1,
    OP_PUTAT  = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  // classified command held in the queue
  typedef struct packed {
    op_t              op;
    logic [7:0]       ch;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [3:0]       bg;
    logic [3:0]       fg;
  } cmd_t;

  typedef struct packed {
    logic [3:0] text_color;
    logic [3:0] back_color;
    logic       scroll_enable;
    logic       cursor_enable;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LIN_W-1:0]  cursor_linear;
    logic              cursor_shown;
  } res_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [3:0] bg,
                                                  input logic [3:0] fg,
                                                  input logic [7:0] c);
    make_cell = {bg, fg, c};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    cell_addr = ADDR_W'(int'(col) + int'(row) * COLUMNS);
  endfunction

  function automatic res_t make_res(input logic [CELL_W-1:0] data,
                                    input logic [COL_W-1:0]  col,
                                    input logic [ROW_W-1:0]  row,
                                    input logic              cen);
    res_t r;
    r.cell_data     = data;
    r.cursor_col    = col;
    r.cursor_row    = row;
    r.cursor_linear = LIN_W'(int'(col) + int'(row) * COLUMNS);
    r.cursor_shown  = cen && (int'(row) < ROWS);
    make_res = r;
  endfunction

endpackage

### rtl/core/tce_if.sv
// ----------------------------------------------------------------------------
// tce channel interfaces
// valid/ready channels for commands, results and register writes
// ----------------------------------------------------------------------------
interface tce_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] ch;
  logic [7:0] col_in;
  logic [7:0] row_in;
  logic [2:0] at_back_color;
  logic [3:0] at_text_color;

  modport source (output valid, op, ch, col_in, row_in, at_back_color,
                  at_text_color, input ready);
  modport sink   (input valid, op, ch, col_in, row_in, at_back_color,
                  at_text_color, output ready);
endinterface

interface tce_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_data;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_linear;
  logic        cursor_shown;

  modport source (output valid, cell_data, cursor_col, cursor_row, cursor_linear,
                  cursor_shown, input ready);
  modport sink   (input valid, cell_data, cursor_col, cursor_row, cursor_linear,
                  cursor_shown, output ready);
endinterface

interface tce_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/tce_front.sv
// ----------------------------------------------------------------------------
// tce_front
// accepts command transactions, clamps coordinates and builds queue entries
// ----------------------------------------------------------------------------
module tce_front import tce_pkg::*; (
  tce_in_if.sink     in_ch,
  input  logic       q_full,
  input  logic       init_busy,
  input  cfg_t       cfg,
  output logic       push,
  output cmd_t       cmd
);

  logic        [COL_W-1:0] col_c;
  logic        [ROW_W-1:0] row_c;

  // clamp signed column to the screen
  always_comb begin
    if (in_ch.col_in[7]) begin
      col_c = '0;
    end else if (int'(in_ch.col_in[6:0]) >= COLUMNS) begin
      col_c = COL_W'(COLUMNS - 1);
    end else begin
      col_c = COL_W'(in_ch.col_in[6:0]);
    end
  end

  // clamp signed row to the screen
  always_comb begin
    if (in_ch.row_in[7]) begin
      row_c = '0;
    end else if (int'(in_ch.row_in[6:0]) >= ROWS) begin
      row_c = ROW_W'(ROWS - 1);
    end else begin
      row_c = ROW_W'(in_ch.row_in[6:0]);
    end
  end

  // colors: put char at uses its own, everything else the registers
  always_comb begin
    cmd.op  = op_t'(in_ch.op);
    cmd.ch  = in_ch.ch;
    cmd.col = col_c;
    cmd.row = row_c;
    if (op_t'(in_ch.op) == OP_PUTAT) begin
      cmd.bg = {1'b0, in_ch.at_back_color};
      cmd.fg = in_ch.at_text_color;
    end else begin
      cmd.bg = cfg.back_color;
      cmd.fg = cfg.text_color;
    end
  end

  assign in_ch.ready = !q_full && !init_busy;
  assign push        = in_ch.valid && in_ch.ready;

endmodule

### rtl/core/tce_queue.sv
// ----------------------------------------------------------------------------
// tce_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module tce_queue import tce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = slot_r[rp_r];

endmodule

### rtl/core/tce_back.sv
// ----------------------------------------------------------------------------
// tce_back
// executes commands against the cell store and drives the result register
// ----------------------------------------------------------------------------
module tce_back import tce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic q_pop,
  output logic init_busy,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic [CELL_W-1:0] mem [CELLS];

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              dv_r, dv_nxt;
  logic              dmem_r, dmem_nxt;
  logic [ADDR_W-1:0] daddr_r, daddr_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic [CELL_W-1:0] rdata_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic              out_free;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [CELL_W-1:0] wd;
  logic [ADDR_W-1:0] ra;

  // put char evaluation
  logic [7:0]        pc_c;
  logic [ROW_W-1:0]  pc_r;
  logic              pc_we;
  logic [COL_W-1:0]  pc_wcol;
  logic [ROW_W-1:0]  pc_wrow;
  logic [7:0]        pc_wch;
  logic              pc_scroll;
  logic [COL_W-1:0]  pc_col0;
  logic [ROW_W-1:0]  pc_row0;

  assign out_free = !out_valid_r || out_ready;

  // start point: cursor for put char, given place for put char at
  always_comb begin
    if (q_head.op == OP_PUTAT) begin
      pc_col0 = q_head.col;
      pc_row0 = q_head.row;
    end else begin
      pc_col0 = col_r;
      pc_row0 = row_r;
    end
  end

  // character rules, wrap and scroll decision
  always_comb begin
    pc_c    = {1'b0, pc_col0};
    pc_r    = pc_row0;
    pc_we   = 1'b0;
    pc_wcol = pc_col0;
    pc_wrow = pc_row0;
    pc_wch  = q_head.ch;
    case (q_head.ch)
      CH_BS: begin
        if (pc_c != '0) begin
          pc_c = pc_c - 8'd1;
        end else if (pc_r != '0) begin
          pc_r = pc_r - ROW_W'(1);
          pc_c = 8'(COLUMNS - 1);
        end
        pc_we   = int'(pc_r) < ROWS;
        pc_wcol = COL_W'(pc_c);
        pc_wrow = pc_r;
        pc_wch  = CH_NUL;
      end
      CH_TAB: begin
        pc_c = pc_c + 8'(TAB_WIDTH) - (pc_c % 8'(TAB_WIDTH));
      end
      CH_CR: begin
        pc_c = '0;
      end
      CH_LF: begin
        pc_c = '0;
        if (int'(pc_r) < ROWS) begin
          pc_r = pc_r + ROW_W'(1);
        end
      end
      default: begin
        pc_we = int'(pc_r) < ROWS;
        pc_c  = pc_c + 8'd1;
      end
    endcase
    if (int'(pc_c) >= COLUMNS) begin
      pc_c = '0;
      if (int'(pc_r) < ROWS) begin
        pc_r = pc_r + ROW_W'(1);
      end
    end
    pc_scroll = cfg.scroll_enable && (int'(pc_r) >= ROWS);
    if (pc_scroll) begin
      pc_r = ROW_W'(ROWS - 1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (int'(idx_r) == CELLS - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid && out_free) begin
          case (q_head.op)
            OP_PUT, OP_PUTAT: if (pc_scroll) state_nxt = ST_SCROLL;
            OP_READ:          state_nxt = ST_READ;
            OP_CLEAR:         state_nxt = ST_CLEAR;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_SCROLL: begin
        if (int'(idx_r) == CELLS) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (int'(idx_r) == CELLS - 1) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    idx_nxt       = idx_r;
    dv_nxt        = 1'b0;
    dmem_nxt      = 1'b0;
    daddr_nxt     = daddr_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wa            = '0;
    wd            = fill_r;
    ra            = '0;
    case (state_r)
      ST_INIT: begin
        we      = 1'b1;
        wa      = idx_r[ADDR_W-1:0];
        wd      = INIT_CELL;
        idx_nxt = idx_r + CNT_W'(1);
      end
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          idx_nxt = '0;
          case (q_head.op)
            OP_PUT, OP_PUTAT: begin
              we = pc_we;
              wa = cell_addr(pc_wcol, pc_wrow);
              wd = make_cell(q_head.bg, q_head.fg, pc_wch);
              if (q_head.op == OP_PUT) begin
                col_nxt = COL_W'(pc_c);
                row_nxt = pc_r;
              end
              fill_nxt = make_cell(q_head.bg, q_head.fg, CH_SPACE);
              if (!pc_scroll) begin
                out_valid_nxt = 1'b1;
                res_nxt = make_res('0, col_nxt, row_nxt, cfg.cursor_enable);
              end
            end
            OP_SETPOS: begin
              col_nxt       = q_head.col;
              row_nxt       = q_head.row;
              out_valid_nxt = 1'b1;
              res_nxt = make_res('0, col_nxt, row_nxt, cfg.cursor_enable);
            end
            OP_READ: begin
              ra = cell_addr(q_head.col, q_head.row);
            end
            OP_CLEAR: begin
              col_nxt  = '0;
              row_nxt  = '0;
              fill_nxt = make_cell(cfg.back_color, cfg.text_color, CH_NUL);
            end
            default: begin
              out_valid_nxt = 1'b1;
              res_nxt = make_res('0, col_r, row_r, cfg.cursor_enable);
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        res_nxt = make_res(rdata_r, col_r, row_r, cfg.cursor_enable);
      end
      ST_SCROLL: begin
        // delayed write of the cell read in the previous cycle, or a blank
        we = dv_r;
        wa = daddr_r;
        wd = dmem_r ? rdata_r : fill_r;
        if (int'(idx_r) == CELLS) begin
          out_valid_nxt = 1'b1;
          res_nxt = make_res('0, col_r, row_r, cfg.cursor_enable);
        end else begin
          dv_nxt    = 1'b1;
          daddr_nxt = idx_r[ADDR_W-1:0];
          if (int'(idx_r) < CELLS - COLUMNS) begin
            dmem_nxt = 1'b1;
            ra       = ADDR_W'(int'(idx_r) + COLUMNS);
          end
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_CLEAR: begin
        we      = 1'b1;
        wa      = idx_r[ADDR_W-1:0];
        wd      = fill_r;
        idx_nxt = idx_r + CNT_W'(1);
        if (int'(idx_r) == CELLS - 1) begin
          out_valid_nxt = 1'b1;
          res_nxt = make_res('0, col_r, row_r, cfg.cursor_enable);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      idx_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      idx_r       <= idx_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dmem_r  <= dmem_nxt;
    daddr_r <= daddr_nxt;
    fill_r  <= fill_nxt;
    res_r   <= res_nxt;
  end

  // cell store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  assign init_busy = state_r == ST_INIT;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

### rtl/core/text_console_character_engine.sv
// printable, control and set-position commands give a result in the cycle after
// leaving the queue, a cell read after the read state; puts and set-position
// commands are taken one per cycle while the result is taken and no scroll is due;
// scroll and clear hold the back end for a pass over the store, set by the single
// write port of the cell store; after reset a clearing pass over all CELLS (2000)
// cells fills the store, no command is taken during it, register writes are
// ----------------------------------------------------------------------------
// text_console_character_engine
// text-mode screen engine: cell store, cursor, wrap, scroll and clear
// ----------------------------------------------------------------------------
`include "text_console_character_engine_defines.svh"

module text_console_character_engine import tce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tce_in_if.sink     in_if,
  tce_out_if.source  out_if,
  tce_cfg_if.sink    cfg_if
);

  cfg_t cfg_r, cfg_nxt;
  logic push, pop, q_full, q_ne, init_busy, out_valid;
  cmd_t push_cmd, head;
  res_t res;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_TEXT_COLOR:    cfg_nxt.text_color    = cfg_if.data;
        REG_BACK_COLOR:    cfg_nxt.back_color    = cfg_if.data;
        REG_SCROLL_ENABLE: cfg_nxt.scroll_enable = cfg_if.data[0];
        REG_CURSOR_ENABLE: cfg_nxt.cursor_enable = cfg_if.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{text_color: 4'h7, back_color: 4'h0, scroll_enable: 1'b0,
                 cursor_enable: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_if.ready = 1'b1;

  tce_front u_front (
    .in_ch     (in_if),
    .q_full    (q_full),
    .init_busy (init_busy),
    .cfg       (cfg_r),
    .push      (push),
    .cmd       (push_cmd)
  );

  tce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_ne),
    .head      (head)
  );

  tce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_ne),
    .q_head    (head),
    .q_pop     (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  // result channel
  assign out_if.valid         = out_valid;
  assign out_if.cell_data     = res.cell_data;
  assign out_if.cursor_col    = res.cursor_col;
  assign out_if.cursor_row    = res.cursor_row;
  assign out_if.cursor_linear = res.cursor_linear;
  assign out_if.cursor_shown  = res.cursor_shown;

  // checks
  `TCE_ASSERT_NEVER(a_no_accept_in_init, in_if.valid && in_if.ready && init_busy)
  `TCE_ASSERT_NEVER(a_no_push_when_full, push && q_full && !pop)
  `TCE_ASSERT_IMPLIES(a_shown_on_screen, out_if.valid && out_if.cursor_shown,
                      int'(out_if.cursor_row) < ROWS)
  `TCE_ASSERT_NEXT(a_pop_needs_entry, pop && !q_ne, 1'b0)

endmodule
